@@ rtl/core/uer_pkg.sv @@
// ----------------------------------------------------------------------------
// uer_pkg
// Shared widths, register indexes, reset values and the control/status
// bundles that pass between the ranger controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

   // Default build values
   localparam int RING_DEPTH_DEF = 10;
   localparam int COUNT_TOP_DEF  = 60000;

   // Field widths
   localparam int WIDTH_W    = 16;
   localparam int DIST_W     = 16;
   localparam int ELAPSED_W  = 17;
   localparam int DEPTH_W    = 4;
   localparam int HOLDOFF_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = '1;

   // Distance scaling: sum * 17 / (depth * 10)
   localparam int SCALE_MUL   = 17;
   localparam int SCALE_SHIFT = 4;
   localparam int SCALE_DIV   = 10;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_AVERAGE_DEPTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF_MS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE        = 2'd2;

   // Register reset values
   localparam logic [DEPTH_W-1:0]   DEPTH_RST   = 4'd1;
   localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = 16'd100;
   localparam logic                 ENABLE_RST  = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic tick;
      logic sum_step;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sum_last;
      logic div_last;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/core/uer_if.sv @@
// ----------------------------------------------------------------------------
// uer_if
// Valid/ready channel interfaces for the tick, result and register ports.
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_req_if;
   logic valid;
   logic ready;
   logic echo_level;
   logic ms_strobe;
   logic read_request;

   modport source (output valid, echo_level, ms_strobe, read_request, input ready);
   modport sink   (input valid, echo_level, ms_strobe, read_request, output ready);
endinterface

interface uer_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        trigger_out;
   logic [uer_pkg::DIST_W-1:0]  distance;
   logic                        sample_stored;

   modport source (output valid, trigger_out, distance, sample_stored, input ready);
   modport sink   (input valid, trigger_out, distance, sample_stored, output ready);
endinterface

interface uer_csr_if;
   logic                            valid;
   logic                            ready;
   logic [uer_pkg::CSR_IDX_W-1:0]   index;
   logic [uer_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/uer_ctrl.sv @@
// ----------------------------------------------------------------------------
// uer_ctrl
// Controller: takes one tick beat at a time, steps the averaging sum and
// the serial divider on a read, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_read,
   output logic                  req_ready,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   input  wire uer_pkg::sts_type sts,
   output uer_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   // Sequence the work of one tick
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.tick = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_read ? ST_SUM : ST_DONE;
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_last) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A read tick goes to the summing loop
   a_read_sums: assert property (@(posedge clock) disable iff (reset)
      accept && req_read |=> state_ff == ST_SUM)
      else $error("read tick did not start the sum");

   // Never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff || rsp_ready)
      else $error("output register overwritten");

   // Finishing a tick leaves a result on offer and frees the input
   a_done_offers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)
      |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished tick not offered");

endmodule

`default_nettype wire

@@ rtl/core/uer_dp.sv @@
// ----------------------------------------------------------------------------
// uer_dp
// Datapath: configuration registers, echo capture, trigger sequencer,
// width ring, one-adder averaging sum and bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_dp #(
   parameter int RING_DEPTH = uer_pkg::RING_DEPTH_DEF,
   parameter int COUNT_TOP  = uer_pkg::COUNT_TOP_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire uer_pkg::cmd_type                cmd,
   output uer_pkg::sts_type                     sts,
   input  wire logic                            echo_level,
   input  wire logic                            ms_strobe,
   input  wire logic                            read_request,
   input  wire logic                            csr_we,
   input  wire logic [uer_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [uer_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                                 trigger_out,
   output logic [uer_pkg::DIST_W-1:0]           distance,
   output logic                                 sample_stored
);

   localparam int WIDTH_W   = uer_pkg::WIDTH_W;
   localparam int ELAPSED_W = uer_pkg::ELAPSED_W;
   localparam int DEPTH_W   = uer_pkg::DEPTH_W;
   localparam int HOLDOFF_W = uer_pkg::HOLDOFF_W;
   localparam int DIST_W    = uer_pkg::DIST_W;
   localparam int SLOT_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W     = $clog2(RING_DEPTH + 1);
   localparam int SUM_W     = WIDTH_W + $clog2(RING_DEPTH);
   localparam int SCALED_W  = SUM_W + $clog2(uer_pkg::SCALE_MUL);
   localparam int DIV_W     = $clog2(RING_DEPTH * uer_pkg::SCALE_DIV + 1);
   localparam int STEP_W    = $clog2(SCALED_W + 1);

   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
   localparam logic [WIDTH_W-1:0] CNT_TOP   = WIDTH_W'(COUNT_TOP);
   localparam logic [DEPTH_W:0]   DEPTH_MAX = (DEPTH_W + 1)'(RING_DEPTH);

   localparam logic [1:0] CAP_IDLE    = 2'd0;
   localparam logic [1:0] CAP_ARMED   = 2'd1;
   localparam logic [1:0] CAP_MEASURE = 2'd2;

   localparam logic [1:0] SEQ_START   = 2'd0;
   localparam logic [1:0] SEQ_TRIGGER = 2'd1;
   localparam logic [1:0] SEQ_HOLDOFF = 2'd2;

   // Configuration registers
   logic [DEPTH_W-1:0]   depth_ff;
   logic [HOLDOFF_W-1:0] holdoff_ff;
   logic                 enable_ff;

   // Tick state
   logic [WIDTH_W-1:0]   ring_ff [RING_DEPTH];
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [1:0]           cap_ff, cap_in;
   logic [1:0]           seq_ff, seq_in;
   logic [WIDTH_W-1:0]   cnt_ff, cnt_in, cnt_adv;
   logic                 counting_ff, counting_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic                 last_echo_ff;
   logic                 store_en, stored_in;
   logic                 stored_ff, read_ff;

   // Averaging and division
   logic [SLOT_W-1:0]    ptr_ff, ptr_dec;
   logic [CNT_W-1:0]     left_ff, depth_eff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SCALED_W-1:0]  quot_ff;
   logic [DIV_W-1:0]     rem_ff, divisor;
   logic [DIV_W:0]       trial;
   logic                 trial_ge;
   logic [STEP_W-1:0]    step_ff;

   // Output register
   logic                 trig_out_ff;
   logic [DIST_W-1:0]    dist_out_ff;
   logic                 stored_out_ff;

   // Register writes; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= uer_pkg::DEPTH_RST;
         holdoff_ff <= uer_pkg::HOLDOFF_RST;
         enable_ff  <= uer_pkg::ENABLE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            uer_pkg::REG_AVERAGE_DEPTH: depth_ff   <= csr_data[DEPTH_W-1:0];
            uer_pkg::REG_HOLDOFF_MS:    holdoff_ff <= csr_data[HOLDOFF_W-1:0];
            uer_pkg::REG_ENABLE:        enable_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Counter, echo edge and millisecond sequencer for one tick
   always_comb begin
      cnt_adv = cnt_ff;
      if (counting_ff) begin
         cnt_adv = (cnt_ff >= CNT_TOP) ? '0 : cnt_ff + 1'b1;
      end

      cnt_in      = cnt_adv;
      counting_in = counting_ff;
      cap_in      = cap_ff;
      slot_in     = slot_ff;
      store_en    = 1'b0;
      stored_in   = 1'b0;
      if (echo_level != last_echo_ff) begin
         unique case (cap_ff)
            CAP_ARMED: begin
               cnt_in      = '0;
               counting_in = 1'b1;
               cap_in      = CAP_MEASURE;
            end
            CAP_MEASURE: begin
               store_en    = 1'b1;
               stored_in   = 1'b1;
               slot_in     = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
               counting_in = 1'b0;
               cap_in      = CAP_IDLE;
            end
            default: ;
         endcase
      end

      elapsed_inc = (elapsed_ff == uer_pkg::ELAPSED_TOP) ? elapsed_ff : elapsed_ff + 1'b1;
      elapsed_in  = elapsed_ff;
      seq_in      = seq_ff;
      if (ms_strobe) begin
         elapsed_in = elapsed_inc;
         if (enable_ff) begin
            unique case (seq_ff)
               SEQ_TRIGGER: begin
                  if (elapsed_inc > ELAPSED_W'(1)) begin
                     elapsed_in = '0;
                     seq_in     = SEQ_HOLDOFF;
                  end
               end
               SEQ_HOLDOFF: begin
                  if (elapsed_inc > ELAPSED_W'(holdoff_ff)) begin
                     seq_in = SEQ_START;
                  end
               end
               default: begin
                  elapsed_in = '0;
                  cap_in     = CAP_ARMED;
                  seq_in     = SEQ_TRIGGER;
               end
            endcase
         end
      end
   end

   // Commit the tick
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         slot_ff      <= '0;
         cap_ff       <= CAP_IDLE;
         seq_ff       <= SEQ_START;
         cnt_ff       <= '0;
         counting_ff  <= 1'b0;
         elapsed_ff   <= '0;
         last_echo_ff <= 1'b0;
      end else if (cmd.tick) begin
         if (store_en) begin
            ring_ff[slot_ff] <= cnt_in;
         end
         slot_ff      <= slot_in;
         cap_ff       <= cap_in;
         seq_ff       <= seq_in;
         cnt_ff       <= cnt_in;
         counting_ff  <= counting_in;
         elapsed_ff   <= elapsed_in;
         last_echo_ff <= echo_level;
      end
   end

   // Clamp the averaging depth to the ring
   always_comb begin
      if (depth_ff == '0) begin
         depth_eff = CNT_W'(1);
      end else if ({1'b0, depth_ff} > DEPTH_MAX) begin
         depth_eff = CNT_W'(RING_DEPTH);
      end else begin
         depth_eff = CNT_W'(depth_ff);
      end
      divisor = (DIV_W'(depth_eff) << 3) + (DIV_W'(depth_eff) << 1);
   end

   // Walk back from the newest slot, one width per cycle
   assign ptr_dec      = (ptr_ff == '0) ? LAST_SLOT : ptr_ff - 1'b1;
   assign sts.sum_last = (left_ff == CNT_W'(1));

   // Restoring division, one quotient bit per cycle
   assign trial        = {rem_ff, quot_ff[SCALED_W-1]};
   assign trial_ge     = (trial >= {1'b0, divisor});
   assign sts.div_last = (step_ff == STEP_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.tick) begin
         ptr_ff    <= slot_in;
         sum_ff    <= '0;
         left_ff   <= depth_eff;
         stored_ff <= stored_in;
         read_ff   <= read_request;
      end
      if (cmd.sum_step) begin
         sum_ff  <= sum_ff + SUM_W'(ring_ff[ptr_dec]);
         ptr_ff  <= ptr_dec;
         left_ff <= left_ff - 1'b1;
      end
      if (cmd.div_start) begin
         quot_ff <= (SCALED_W'(sum_ff) << uer_pkg::SCALE_SHIFT) + SCALED_W'(sum_ff);
         rem_ff  <= '0;
         step_ff <= STEP_W'(SCALED_W);
      end
      if (cmd.div_step) begin
         rem_ff  <= trial_ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
         quot_ff <= {quot_ff[SCALED_W-2:0], trial_ge};
         step_ff <= step_ff - 1'b1;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         trig_out_ff   <= (seq_ff == SEQ_TRIGGER);
         dist_out_ff   <= read_ff ? quot_ff[DIST_W-1:0] : '0;
         stored_out_ff <= stored_ff;
      end
   end

   assign trigger_out   = trig_out_ff;
   assign distance      = dist_out_ff;
   assign sample_stored = stored_out_ff;

   // A stored width always ends the measurement
   a_store_ends_measure: assert property (@(posedge clock) disable iff (reset)
      cmd.tick && store_en |=> cap_ff != CAP_MEASURE && !counting_ff)
      else $error("measurement still running after store");

   // The summing loop never runs past the depth
   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_step |-> left_ff != '0)
      else $error("sum stepped past depth");

   // The write slot stays inside the ring
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      cmd.tick |=> slot_ff <= LAST_SLOT)
      else $error("write slot outside ring");

endmodule

`default_nettype wire

@@ rtl/core/ultrasonic_echo_ranger.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Pulse-width ultrasonic rangefinder with trigger sequencer and averaging.
// ----------------------------------------------------------------------------
// Each req beat is one microsecond tick and yields exactly one rsp beat. A
// tick without a read is taken with an update of the capture and sequencer
// state, and its result moves into the output register once that is free.
// On a read tick the newest widths are summed through a single adder, one
// ring entry per cycle, and the scaled sum is divided by depth*10 in a
// restoring divider that yields one quotient bit per cycle, before the
// result moves on. The output register lets a new tick be taken while the
// last result waits. Registers are to be written through the csr port only
// while no tick is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger #(
   parameter int RING_DEPTH = uer_pkg::RING_DEPTH_DEF,
   parameter int COUNT_TOP  = uer_pkg::COUNT_TOP_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   uer_req_if.sink   req_bus,
   uer_rsp_if.source rsp_bus,
   uer_csr_if.sink   csr_bus
);

   uer_pkg::cmd_type cmd;
   uer_pkg::sts_type sts;
   logic             csr_we;

   // Register port never stalls
   assign csr_bus.ready = 1'b1;
   assign csr_we        = csr_bus.valid;

   uer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_read  (req_bus.read_request),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   uer_dp #(
      .RING_DEPTH (RING_DEPTH),
      .COUNT_TOP  (COUNT_TOP)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .echo_level    (req_bus.echo_level),
      .ms_strobe     (req_bus.ms_strobe),
      .read_request  (req_bus.read_request),
      .csr_we        (csr_we),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .trigger_out   (rsp_bus.trigger_out),
      .distance      (rsp_bus.distance),
      .sample_stored (rsp_bus.sample_stored)
   );

endmodule

`default_nettype wire
